@@ rtl/chip8_display_instruction_subset_unit_macros.svh @@
// Assertion macros for the CHIP-8 display instruction subset unit.
// Included by the checker; expects clk and rst_n in the including scope.
`ifndef CHIP8_DISPLAY_INSTRUCTION_SUBSET_UNIT_MACROS_SVH
`define CHIP8_DISPLAY_INSTRUCTION_SUBSET_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define C8DIS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("c8dis same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define C8DIS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("c8dis next-cycle check failed");

`endif

@@ rtl/c8dis_pkg.sv @@
// Shared types, codes and constants for the CHIP-8 display instruction unit.
// No dependencies; compiled before every other file of the block.
package c8dis_pkg;

  localparam int DEF_SCREEN_WIDTH  = 64;
  localparam int DEF_SCREEN_HEIGHT = 32;
  localparam int DEF_MEM_BYTES     = 4096;

  // Fixed field widths of the request and result beats.
  localparam int REQ_W    = 2;
  localparam int OPCODE_W = 16;
  localparam int ADDR_W   = 12;
  localparam int DATA_W   = 8;
  localparam int PIX_W    = 11;
  localparam int PC_W     = 12;

  localparam logic [PC_W-1:0] PC_START = 12'h200;

  typedef enum logic [REQ_W-1:0] {
    REQ_EXEC   = 2'd0,
    REQ_MEM_WR = 2'd1,
    REQ_PIX_RD = 2'd2
  } c8dis_req_t;

  // Top nibble of the opcode.
  localparam logic [3:0] OP_SYS = 4'h0;
  localparam logic [3:0] OP_JP  = 4'h1;
  localparam logic [3:0] OP_LD  = 4'h6;
  localparam logic [3:0] OP_ADD = 4'h7;
  localparam logic [3:0] OP_LDI = 4'hA;
  localparam logic [3:0] OP_DRW = 4'hD;

  localparam logic [OPCODE_W-1:0] OPC_CLS = 16'h00E0;
  localparam logic [3:0]          VF_IDX  = 4'hF;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } c8dis_mem_ctrl_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } c8dis_fb_ctrl_t;

endpackage

@@ rtl/c8dis_if.sv @@
// Valid/ready channel interfaces for request and result beats.
// Depends on c8dis_pkg for the field widths.
interface c8dis_in_if import c8dis_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [REQ_W-1:0]    req_type;
  logic [OPCODE_W-1:0] opcode;
  logic [ADDR_W-1:0]   mem_addr;
  logic [DATA_W-1:0]   mem_data;
  logic [PIX_W-1:0]    pixel_index;

  modport source (output valid, req_type, opcode, mem_addr, mem_data, pixel_index,
                  input ready);
  modport sink   (input valid, req_type, opcode, mem_addr, mem_data, pixel_index,
                  output ready);
endinterface

interface c8dis_out_if import c8dis_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PC_W-1:0] pc_value;
  logic            frame_dirty;
  logic            collision;
  logic            pixel_value;
  logic            unsupported;

  modport source (output valid, pc_value, frame_dirty, collision, pixel_value, unsupported,
                  input ready);
  modport sink   (input valid, pc_value, frame_dirty, collision, pixel_value, unsupported,
                  output ready);
endinterface

@@ rtl/c8dis_sprite_mem.sv @@
// Byte-wide sprite memory: one write port, one registered read port.
// Depends on c8dis_pkg for the control struct.
module c8dis_sprite_mem import c8dis_pkg::*; #(
  parameter int  MEM_BYTES = DEF_MEM_BYTES,
  localparam int AW        = $clog2(MEM_BYTES)
) (
  input  logic              clk,
  input  c8dis_mem_ctrl_t   ctrl,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_data_r
);

  logic [DATA_W-1:0] mem [MEM_BYTES];

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/c8dis_frame_mem.sv @@
// Frame memory, one row word per entry, with per-row valid bits so that
// reset and a clear need not write every row. Depends on c8dis_pkg.
module c8dis_frame_mem import c8dis_pkg::*; #(
  parameter int  SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int  SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
  localparam int RW            = $clog2(SCREEN_HEIGHT)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  c8dis_fb_ctrl_t          ctrl,
  input  logic [RW-1:0]           rd_addr,
  input  logic [RW-1:0]           wr_addr,
  input  logic [SCREEN_WIDTH-1:0] wr_data,
  output logic [SCREEN_WIDTH-1:0] rd_data
);

  logic [SCREEN_WIDTH-1:0]  mem [SCREEN_HEIGHT];
  logic [SCREEN_WIDTH-1:0]  rd_raw_r;
  logic [SCREEN_HEIGHT-1:0] row_valid_r;
  logic                     rd_valid_r;

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl.rd_en) begin
      rd_raw_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      rd_valid_r  <= 1'b0;
    end else begin
      if (ctrl.clr) begin
        row_valid_r <= '0;
      end else if (ctrl.wr_en) begin
        row_valid_r[wr_addr] <= 1'b1;
      end
      if (ctrl.rd_en) begin
        rd_valid_r <= row_valid_r[rd_addr];
      end
    end
  end

  // A row never written since the last clear reads as dark.
  assign rd_data = rd_valid_r ? rd_raw_r : '0;

endmodule

@@ rtl/chip8_display_instruction_subset_unit.sv @@
// Top level of the CHIP-8 display instruction subset unit: sequencer,
// V/I/PC registers and the two memories. Depends on c8dis_pkg, c8dis_if,
// c8dis_sprite_mem and c8dis_frame_mem.
//
//   channel  direction  modport        beat contents
//   in_ch    input      c8dis_in_if    req_type, opcode, mem_addr, mem_data, pixel_index
//   out_ch   output     c8dis_out_if   pc_value, frame_dirty, collision, pixel_value, unsupported
//
// One request is worked on at a time. A non-draw request goes through the
// decode and done states (a pixel read waits for its frame read between), and
// DXYN through two setup states and, per row actually drawn (at most 15), a
// frame memory read and an XOR write-back. in_ch.ready rises at the same
// edge that loads the result. Reset is synchronous and active low; the
// frame reads as cleared at once through per-row valid bits. A stalled
// result waits in the output register while the next request is taken; a
// second result waits in its final state until that register is free.
module chip8_display_instruction_subset_unit import c8dis_pkg::*; #(
  parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT,
  parameter int MEM_BYTES     = DEF_MEM_BYTES
) (
  input logic         clk,
  input logic         rst_n,
  c8dis_in_if.sink    in_ch,
  c8dis_out_if.source out_ch
);

  localparam int FRAME_PIXELS = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int AW           = $clog2(MEM_BYTES);
  localparam int RW           = $clog2(SCREEN_HEIGHT);
  localparam int CW           = $clog2(SCREEN_WIDTH);

  // Scaled reciprocals of the three divisors, rounded down.
  localparam int RECIP_SH = 20;
  localparam int RECIP_W  = (1 << RECIP_SH) / SCREEN_WIDTH;
  localparam int RECIP_H  = (1 << RECIP_SH) / SCREEN_HEIGHT;
  localparam int RECIP_M  = (1 << RECIP_SH) / MEM_BYTES;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DRAW_Y,
    S_ROW_REQ,
    S_ROW_WAIT,
    S_PIX_WAIT,
    S_DONE
  } state_t;

  // Quotient and remainder by a constant divisor through a reciprocal
  // multiply. The rounded-down reciprocal leaves the first quotient exact or
  // one short, and a single compare and subtract settles it. Every caller
  // keeps the quotient below 256. Result is {quotient, remainder}.
  function automatic logic [20:0] divmod_const(input logic [12:0] val,
                                               input logic [12:0] dvs,
                                               input logic [17:0] recip);
    logic [30:0] prod;
    logic [10:0] quo;
    logic [23:0] back;
    logic [12:0] rem;
    prod = 31'(val) * 31'(recip);
    quo  = prod[30:20];
    back = 24'(quo) * 24'(dvs);
    rem  = val - back[12:0];
    if (rem >= dvs) begin
      rem = rem - dvs;
      quo = quo + 11'd1;
    end
    return {quo[7:0], rem};
  endfunction

  state_t state_r;

  // Captured request beat.
  logic [REQ_W-1:0]    req_r;
  logic [OPCODE_W-1:0] op_r;
  logic [ADDR_W-1:0]   maddr_r;
  logic [DATA_W-1:0]   mdata_r;
  logic [PIX_W-1:0]    pix_r;

  // Architectural registers.
  logic [7:0]      v_r [16];
  logic [11:0]     idx_r;
  logic [PC_W-1:0] pc_r;

  // Draw and read working state.
  logic [CW-1:0] x0_r;
  logic [RW-1:0] y0_r;
  logic [3:0]    row_cnt_r;
  logic          hit_r;
  logic [CW-1:0] col_r;

  // Result being built, and the output register.
  logic            drew_r, coll_r, pval_r, unsup_r;
  logic            out_valid_r;
  logic [PC_W-1:0] out_pc_r;
  logic            out_drew_r, out_coll_r, out_pval_r, out_unsup_r;

  logic [7:0]              vrd;
  logic [20:0]             x_dm, y_dm, pix_dm, spr_dm;
  logic [7:0]              row_sum;
  logic                    row_done;
  logic                    pix_ok;
  logic                    maddr_ok;
  logic [7:0]              spr_rev;
  logic [SCREEN_WIDTH-1:0] spr_base;
  logic [SCREEN_WIDTH-1:0] mask;

  c8dis_mem_ctrl_t         sm_ctrl;
  logic [AW-1:0]           sm_rd_addr;
  logic [DATA_W-1:0]       sm_rd_data;
  c8dis_fb_ctrl_t          fb_ctrl;
  logic [RW-1:0]           fb_rd_addr;
  logic [RW-1:0]           fb_wr_addr;
  logic [SCREEN_WIDTH-1:0] fb_wr_data;
  logic [SCREEN_WIDTH-1:0] fb_rd_data;

  // The V file has a single read port: VX while decoding, VY in the
  // second draw setup cycle.
  assign vrd = v_r[(state_r == S_DRAW_Y) ? op_r[7:4] : op_r[11:8]];

  assign x_dm   = divmod_const(13'(vrd), 13'(SCREEN_WIDTH), 18'(RECIP_W));
  assign y_dm   = divmod_const(13'(vrd), 13'(SCREEN_HEIGHT), 18'(RECIP_H));
  assign pix_dm = divmod_const(13'(pix_r), 13'(SCREEN_WIDTH), 18'(RECIP_W));
  assign spr_dm = divmod_const(13'(idx_r) + 13'(row_cnt_r), 13'(MEM_BYTES),
                               18'(RECIP_M));

  assign row_sum  = 8'(y0_r) + 8'(row_cnt_r);
  assign row_done = (row_cnt_r == op_r[3:0]) || (row_sum >= 8'(SCREEN_HEIGHT));
  assign pix_ok   = {3'b000, pix_r} < 14'(FRAME_PIXELS);
  assign maddr_ok = {1'b0, maddr_r} < 13'(MEM_BYTES);

  // Sprite bit 7 is the leftmost pixel. Shifting into a row-wide word drops
  // the pixels that fall past the right edge.
  always_comb begin
    for (int c = 0; c < 8; c++) begin
      spr_rev[c] = sm_rd_data[7-c];
    end
  end
  assign spr_base = SCREEN_WIDTH'(spr_rev);
  assign mask     = spr_base << x0_r;

  always_comb begin
    sm_ctrl.wr_en = (state_r == S_DECODE) && (req_r == REQ_MEM_WR) && maddr_ok;
    sm_ctrl.rd_en = (state_r == S_ROW_REQ) && !row_done;
    fb_ctrl.rd_en = ((state_r == S_ROW_REQ) && !row_done)
                    || ((state_r == S_DECODE) && (req_r == REQ_PIX_RD) && pix_ok);
    fb_ctrl.wr_en = (state_r == S_ROW_WAIT);
    fb_ctrl.clr   = (state_r == S_DECODE) && (req_r == REQ_EXEC) && (op_r == OPC_CLS);
  end

  assign sm_rd_addr = spr_dm[AW-1:0];
  assign fb_rd_addr = (state_r == S_DECODE) ? pix_dm[13+RW-1:13] : row_sum[RW-1:0];
  assign fb_wr_addr = row_sum[RW-1:0];
  assign fb_wr_data = fb_rd_data ^ mask;

  c8dis_sprite_mem #(
    .MEM_BYTES (MEM_BYTES)
  ) u_sprite_mem (
    .clk       (clk),
    .ctrl      (sm_ctrl),
    .wr_addr   (maddr_r[AW-1:0]),
    .wr_data   (mdata_r),
    .rd_addr   (sm_rd_addr),
    .rd_data_r (sm_rd_data)
  );

  c8dis_frame_mem #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_frame_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (fb_ctrl),
    .rd_addr (fb_rd_addr),
    .wr_addr (fb_wr_addr),
    .wr_data (fb_wr_data),
    .rd_data (fb_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pc_r        <= PC_START;
      idx_r       <= '0;
      for (int i = 0; i < 16; i++) begin
        v_r[i] <= '0;
      end
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            req_r   <= in_ch.req_type;
            op_r    <= in_ch.opcode;
            maddr_r <= in_ch.mem_addr;
            mdata_r <= in_ch.mem_data;
            pix_r   <= in_ch.pixel_index;
            drew_r  <= 1'b0;
            coll_r  <= 1'b0;
            pval_r  <= 1'b0;
            unsup_r <= 1'b0;
            state_r <= S_DECODE;
          end
        end

        S_DECODE: begin
          state_r <= S_DONE;
          case (req_r)
            REQ_EXEC: begin
              pc_r <= pc_r + 12'd2;
              case (op_r[15:12])
                OP_SYS: begin
                  // Only the exact clear word is handled in this group.
                  if (op_r == OPC_CLS) begin
                    drew_r <= 1'b1;
                  end else begin
                    unsup_r <= 1'b1;
                  end
                end
                OP_JP: begin
                  pc_r <= op_r[11:0];
                end
                OP_LD: begin
                  v_r[op_r[11:8]] <= op_r[7:0];
                end
                OP_ADD: begin
                  // Wraps modulo 256; VF is left alone.
                  v_r[op_r[11:8]] <= vrd + op_r[7:0];
                end
                OP_LDI: begin
                  idx_r <= op_r[11:0];
                end
                OP_DRW: begin
                  // The program counter moves when the draw finishes.
                  pc_r      <= pc_r;
                  x0_r      <= x_dm[CW-1:0];
                  row_cnt_r <= '0;
                  hit_r     <= 1'b0;
                  state_r   <= S_DRAW_Y;
                end
                default: begin
                  unsup_r <= 1'b1;
                end
              endcase
            end
            REQ_PIX_RD: begin
              if (pix_ok) begin
                col_r   <= pix_dm[CW-1:0];
                state_r <= S_PIX_WAIT;
              end
            end
            default: begin
              // Memory writes are issued combinationally this cycle; an
              // unknown request changes nothing.
            end
          endcase
        end

        S_DRAW_Y: begin
          y0_r    <= y_dm[RW-1:0];
          state_r <= S_ROW_REQ;
        end

        S_ROW_REQ: begin
          if (row_done) begin
            v_r[VF_IDX] <= {7'b0000000, hit_r};
            coll_r      <= hit_r;
            drew_r      <= 1'b1;
            pc_r        <= pc_r + 12'd2;
            state_r     <= S_DONE;
          end else begin
            state_r <= S_ROW_WAIT;
          end
        end

        S_ROW_WAIT: begin
          // Row and sprite byte have arrived; the XOR write-back happens now.
          hit_r     <= hit_r | (|(fb_rd_data & mask));
          row_cnt_r <= row_cnt_r + 4'd1;
          state_r   <= S_ROW_REQ;
        end

        S_PIX_WAIT: begin
          pval_r  <= fb_rd_data[col_r];
          state_r <= S_DONE;
        end

        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_pc_r    <= pc_r;
            out_drew_r  <= drew_r;
            out_coll_r  <= coll_r;
            out_pval_r  <= pval_r;
            out_unsup_r <= unsup_r;
            state_r     <= S_IDLE;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.pc_value    = out_pc_r;
  assign out_ch.frame_dirty = out_drew_r;
  assign out_ch.collision   = out_coll_r;
  assign out_ch.pixel_value = out_pval_r;
  assign out_ch.unsupported = out_unsup_r;

endmodule

@@ rtl/c8dis_checker.sv @@
// Port-level checker for the CHIP-8 display instruction unit, bound to the
// top level. Depends on c8dis_if and the assertion macro header.
`include "chip8_display_instruction_subset_unit_macros.svh"

module c8dis_checker (
  input logic         clk,
  input logic         rst_n,
  c8dis_in_if.sink    in_ch,
  c8dis_out_if.source out_ch
);

  logic [15:0] out_beat;
  logic [2:0]  out_kind;

  assign out_beat = {out_ch.pc_value, out_ch.frame_dirty, out_ch.collision,
                     out_ch.pixel_value, out_ch.unsupported};
  assign out_kind = {out_ch.frame_dirty, out_ch.unsupported, out_ch.pixel_value};

  // A stalled result beat stays put.
  `C8DIS_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_beat))

  // Requests are worked one at a time, so ready drops after each accept.
  `C8DIS_ASSERT_NEXT(a_one_in_flight, in_ch.valid && in_ch.ready, !in_ch.ready)

  // A collision can only come from a draw.
  `C8DIS_ASSERT_IMPL(a_coll_from_draw, out_ch.valid && out_ch.collision, out_ch.frame_dirty)

  // Draw, unsupported opcode and pixel read results exclude each other.
  `C8DIS_ASSERT_IMPL(a_flags_exclusive, out_ch.valid, $onehot0(out_kind))

endmodule

bind chip8_display_instruction_subset_unit c8dis_checker u_c8dis_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);
